/* rtl/bbr_pkg.sv */
package bbr_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int WIN_AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    localparam int BW_W     = 24;
    localparam int RTT_W    = 16;
    localparam int GAIN_W   = 9;
    localparam int PHASE_W  = 3;
    localparam int ROUND_W  = 16;
    localparam int INFL_W   = 32;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 24;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 112;

    localparam logic [CFG_AW-1:0] REG_PHASE_START    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PROBE_INTERVAL = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PROBE_DURATION = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PROBE_INFLIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RTT_FLOOR      = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_UP    = 9'd320;
    localparam logic [GAIN_W-1:0] GAIN_DOWN  = 9'd230;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;

    localparam logic [RTT_W-1:0]  RTT_RESET       = 16'd256;
    localparam logic [ROUND_W-1:0] INTERVAL_RESET = 16'd20;
    localparam logic [ROUND_W-1:0] DURATION_RESET = 16'd4;
    localparam logic [BW_W-1:0]   INFLIGHT_RESET  = 24'd1024;
    localparam logic [RTT_W-1:0]  FLOOR_RESET     = 16'd512;

    typedef struct packed {
        logic            wr;
        logic [BW_W-1:0] data;
    } t_win_cmd;

    typedef struct packed {
        logic            done;
        logic [BW_W-1:0] peak;
    } t_win_sts;

    function automatic logic [GAIN_W-1:0] gain_of(input logic [PHASE_W-1:0] phase);
        logic [GAIN_W-1:0] g;
        case (phase)
            3'd0:    g = GAIN_UP;
            3'd1:    g = GAIN_DOWN;
            default: g = GAIN_UNITY;
        endcase
        return g;
    endfunction

endpackage

/* rtl/bbr_win.sv */
module bbr_win (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbr_pkg::t_win_cmd i_cmd,
    output bbr_pkg::t_win_sts o_sts
);

    logic [bbr_pkg::BW_W-1:0]   r_win [bbr_pkg::WINDOW_LEN];
    logic [bbr_pkg::WIN_AW-1:0] r_slot;
    logic [bbr_pkg::WIN_AW-1:0] r_idx;
    logic                       r_busy;
    logic                       r_done;
    logic [bbr_pkg::BW_W-1:0]   r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bbr_pkg::WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_slot <= '0;
            r_idx  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_peak <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.wr) begin
                r_win[r_slot] <= i_cmd.data;
                if (r_slot == bbr_pkg::WIN_AW'(bbr_pkg::WINDOW_LEN - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
                r_peak <= '0;
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_win[r_idx] > r_peak) begin
                    r_peak <= r_win[r_idx];
                end
                if (r_idx == bbr_pkg::WIN_AW'(bbr_pkg::WINDOW_LEN - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.peak = r_peak;

endmodule

/* rtl/bbr_rate_controller.sv */
// Channel  Dir  Bits  Contents (lowest bit first)
// s_axis   in   40    delivered_bw[23:0], rtt_sample[39:24]
// m_axis   out  112   sending_rate, inflight_target, gain_out, probe_mode,
//                     cycle_phase, bw_estimate, rtt_estimate, zero pad
// cfg      in   24    write enable, index 0..4, data
//
// From accept to result, one item passes through the one-entry-per-cycle window
// scan, the estimate update and two passes through the shared multiplier.
// Ready is high only while the sequencer is idle.
// Reset is synchronous and clears the window. A stalled result holds in the
// output register; the next item is accepted while it waits.
module bbr_rate_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // delivered_bw[23:0], rtt_sample[39:24]
    input  logic [bbr_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // sending_rate[23:0], inflight_target[55:24], gain_out[64:56],
    // probe_mode[65], cycle_phase[68:66], bw_estimate[92:69],
    // rtt_estimate[108:93], zero[111:109]
    output logic [bbr_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [bbr_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [bbr_pkg::CFG_DW-1:0]     i_cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } t_state;

    t_state r_state;

    logic [bbr_pkg::ROUND_W-1:0] r_intv;
    logic [bbr_pkg::ROUND_W-1:0] r_dur;
    logic [bbr_pkg::BW_W-1:0]    r_pinfl;
    logic [bbr_pkg::RTT_W-1:0]   r_floor;

    logic [bbr_pkg::RTT_W-1:0]   r_lowest;
    logic                        r_mode;
    logic [bbr_pkg::PHASE_W-1:0] r_cycle;
    logic [bbr_pkg::ROUND_W-1:0] r_round;
    logic [bbr_pkg::ROUND_W-1:0] r_pbegin;
    logic [bbr_pkg::ROUND_W-1:0] r_rpbegin;

    logic [bbr_pkg::RTT_W-1:0]   r_rtt;
    logic [bbr_pkg::GAIN_W-1:0]  r_gain;
    logic                        r_use_bw;
    logic [32:0]                 r_prod1;
    logic [48:0]                 r_prod2;

    logic                        r_m_tvalid;
    logic [bbr_pkg::M_DATA_W-1:0] r_m_tdata;

    logic [bbr_pkg::RTT_W-1:0]   n_lowest;
    logic                        n_mode;
    logic [bbr_pkg::PHASE_W-1:0] n_cycle;
    logic [bbr_pkg::ROUND_W-1:0] n_round;
    logic [bbr_pkg::ROUND_W-1:0] n_pbegin;
    logic [bbr_pkg::ROUND_W-1:0] n_rpbegin;
    logic [bbr_pkg::GAIN_W-1:0]  n_gain;
    logic                        n_use_bw;
    logic [bbr_pkg::ROUND_W-1:0] el_dur;
    logic [bbr_pkg::ROUND_W-1:0] el_intv;

    logic [32:0]                 mul_a;
    logic [15:0]                 mul_b;
    logic [48:0]                 mul_p;

    logic [bbr_pkg::BW_W-1:0]    rate_sat;
    logic [bbr_pkg::INFL_W-1:0]  infl_sat;
    logic [bbr_pkg::INFL_W-1:0]  infl_out;

    bbr_pkg::t_win_cmd win_cmd;
    bbr_pkg::t_win_sts win_sts;

    logic s_acc;
    logic out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_tvalid || i_m_tready;

    assign win_cmd.wr   = s_acc;
    assign win_cmd.data = i_s_tdata[23:0];

    bbr_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .o_sts   (win_sts)
    );

    always_comb begin
        n_lowest  = r_lowest;
        n_pbegin  = r_pbegin;
        n_rpbegin = r_rpbegin;
        n_mode    = r_mode;
        n_cycle   = r_cycle;
        n_round   = r_round + 1'b1;
        n_gain    = bbr_pkg::GAIN_UNITY;
        n_use_bw  = 1'b0;
        if (r_rtt <= r_lowest) begin
            n_lowest = (r_rtt < r_floor) ? r_floor : r_rtt;
            n_pbegin = r_round;
        end
        el_dur = n_round - r_rpbegin;
        if (r_mode) begin
            if (el_dur >= r_dur) begin
                n_mode = 1'b0;
            end
        end else begin
            n_cycle = r_cycle + 1'b1;
        end
        el_intv = n_round - n_pbegin;
        if (!n_mode) begin
            n_gain   = bbr_pkg::gain_of(n_cycle);
            n_use_bw = 1'b1;
            if (el_intv >= r_intv) begin
                n_pbegin  = n_round;
                n_rpbegin = n_round;
                n_mode    = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_state == ST_MUL2) begin
            mul_a = r_prod1;
            mul_b = r_lowest;
        end else begin
            mul_a = {9'd0, win_sts.peak};
            mul_b = {7'd0, r_gain};
        end
    end

    assign mul_p = mul_a * mul_b;

    assign rate_sat = (r_prod1[32] != 1'b0) ? {bbr_pkg::BW_W{1'b1}} : r_prod1[31:8];
    assign infl_sat = (r_prod2[48] != 1'b0) ? {bbr_pkg::INFL_W{1'b1}} : r_prod2[47:16];
    assign infl_out = r_use_bw ? infl_sat : {8'd0, r_pinfl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_intv        <= bbr_pkg::INTERVAL_RESET;
            r_dur         <= bbr_pkg::DURATION_RESET;
            r_pinfl       <= bbr_pkg::INFLIGHT_RESET;
            r_floor       <= bbr_pkg::FLOOR_RESET;
            r_lowest      <= bbr_pkg::RTT_RESET;
            r_mode        <= 1'b0;
            r_cycle       <= '0;
            r_round       <= '0;
            r_pbegin      <= '0;
            r_rpbegin     <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready && r_state != ST_OUT) begin
                r_m_tvalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bbr_pkg::REG_PHASE_START: begin
                        r_cycle       <= i_cfg_wdata[2:0];
                    end
                    bbr_pkg::REG_PROBE_INTERVAL: r_intv  <= i_cfg_wdata[15:0];
                    bbr_pkg::REG_PROBE_DURATION: r_dur   <= i_cfg_wdata[15:0];
                    bbr_pkg::REG_PROBE_INFLIGHT: r_pinfl <= i_cfg_wdata;
                    bbr_pkg::REG_RTT_FLOOR:      r_floor <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_rtt   <= i_s_tdata[39:24];
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (win_sts.done) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_lowest  <= n_lowest;
                    r_mode    <= n_mode;
                    r_cycle   <= n_cycle;
                    r_round   <= n_round;
                    r_pbegin  <= n_pbegin;
                    r_rpbegin <= n_rpbegin;
                    r_gain    <= n_gain;
                    r_use_bw  <= n_use_bw;
                    r_state   <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_prod1 <= mul_p[32:0];
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_prod2 <= mul_p;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {3'd0, r_lowest, win_sts.peak, r_cycle, r_mode,
                                       r_gain, infl_out, rate_sat};
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

/* rtl/bbr_chk.sv */
module bbr_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         i_s_tready,
    input logic                         i_m_tvalid,
    input logic                         i_m_tready,
    input logic [bbr_pkg::M_DATA_W-1:0] i_m_tdata
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("ready stayed high after an accepted item");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

    a_gain_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[64:56] == bbr_pkg::GAIN_UP ||
                        i_m_tdata[64:56] == bbr_pkg::GAIN_DOWN ||
                        i_m_tdata[64:56] == bbr_pkg::GAIN_UNITY))
        else $error("gain outside the cycle table");

    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tdata[92:69] == 24'd0) |-> (i_m_tdata[23:0] == 24'd0))
        else $error("nonzero rate with zero bandwidth estimate");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_m_tvalid && i_s_tready))
        else $error("block not idle after reset");

endmodule

bind bbr_rate_controller bbr_chk u_bbr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
